[sv/dia_pkg.sv]
package dia_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = 10;
  localparam int INDEX_W   = 11;
  localparam int STRIDE_W  = 13;
  localparam int ADDR_W    = 48;
  localparam int PROD_W    = SLOT_W + STRIDE_W;

  localparam logic [INDEX_W-1:0] NULL_INDEX = INDEX_W'(MAX_SLOTS);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_XLATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_STRIDE   = 2'd1,
    REG_BASE     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [INDEX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    logic [ADDR_W-1:0]  slot_address;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  capacity;
    logic [STRIDE_W-1:0] slot_stride;
    logic [ADDR_W-1:0]   base_address;
  } cfg_t;

endpackage

[sv/dia_ram.sv]
module dia_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/dia_core.sv]
module dia_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  dia_pkg::req_t item,
  input  dia_pkg::cfg_t cfg,
  output dia_pkg::rsp_t result
);
  import dia_pkg::*;

  logic [INDEX_W-1:0] count;
  logic [INDEX_W-1:0] count_next;
  logic [INDEX_W-1:0] high_water;
  logic [INDEX_W-1:0] high_water_next;
  logic [SLOT_W-1:0]  tos;
  logic               top_pend;
  logic [SLOT_W-1:0]  rd_data;
  logic [SLOT_W-1:0]  top;
  logic [INDEX_W-1:0] idx;
  logic [INDEX_W-1:0] cap;
  logic [INDEX_W-1:0] below;
  logic [INDEX_W-1:0] res_index;
  status_t            res_status;
  logic               push;
  logic               pop;
  logic               deep;
  logic [PROD_W-1:0]  product;
  logic [ADDR_W-1:0]  sum;

  assign idx   = item.slot_index[INDEX_W-1] ? NULL_INDEX : item.slot_index;
  assign cap   = (cfg.capacity > NULL_INDEX) ? NULL_INDEX : cfg.capacity;
  // top of stack lives in tos after a push, in the ram read data after a pop
  assign top   = top_pend ? rd_data : tos;
  assign below = count - INDEX_W'(2);
  assign deep  = (count >= INDEX_W'(2));

  always_comb begin
    res_index       = idx;
    res_status      = ST_OK;
    count_next      = count;
    high_water_next = high_water;
    push            = 1'b0;
    pop             = 1'b0;
    unique case (item.cmd)
      CMD_ALLOC: begin
        if (count != '0) begin
          res_index  = {1'b0, top};
          pop        = 1'b1;
          count_next = count - INDEX_W'(1);
        end else if (high_water >= cap) begin
          res_index  = NULL_INDEX;
          res_status = ST_FULL;
        end else begin
          res_index       = high_water;
          high_water_next = high_water + INDEX_W'(1);
        end
      end
      CMD_FREE: begin
        if (idx[INDEX_W-1] || idx >= high_water) begin
          res_status = ST_IGNORED;
        end else if (count == NULL_INDEX) begin
          res_status = ST_OVERFLOW;
        end else begin
          push       = 1'b1;
          count_next = count + INDEX_W'(1);
        end
      end
      CMD_CLEAR: begin
        res_index       = NULL_INDEX;
        count_next      = '0;
        high_water_next = '0;
      end
      CMD_XLATE: begin
        res_index = idx;
      end
      default: begin
        res_index = idx;
      end
    endcase
  end

  dia_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_SLOTS)
  ) u_stack (
    .clk    (clk),
    .wr_en  (step && push),
    .wr_addr(count[SLOT_W-1:0]),
    .wr_data(idx[SLOT_W-1:0]),
    .rd_en  (step && pop && deep),
    .rd_addr(below[SLOT_W-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      high_water <= '0;
      top_pend   <= 1'b0;
    end else if (step) begin
      count      <= count_next;
      high_water <= high_water_next;
      if (push) begin
        top_pend <= 1'b0;
      end else if (pop) begin
        top_pend <= deep;
      end else if (item.cmd == CMD_CLEAR) begin
        top_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && push) begin
      tos <= idx[SLOT_W-1:0];
    end
  end

  assign product = res_index[SLOT_W-1:0] * cfg.slot_stride;
  assign sum     = cfg.base_address + ADDR_W'(product);

  assign result.result_index = res_index;
  assign result.slot_address = res_index[INDEX_W-1] ? '0 : sum;
  assign result.status       = res_status;

endmodule

[sv/descriptor_index_allocator.sv]
// Slot index allocator for a pool of up to 1024 slots. Each request (allocate,
// free, clear, translate) gives exactly one result: the index, its slot
// address base_address + index * slot_stride (48-bit wrap, 0 for the null
// index 1024) and a status. One request is taken every cycle while the
// result side does not stall. A request is captured in the input register,
// passes through one round of allocator logic and its result is captured in
// the result register. A stall on the result side holds the result register
// and the input register. Freed indices go on a LIFO kept in a 1024 x 10
// ram. The top entry is held either in a register or in the ram read data,
// so pops can follow each other with no gap. Registers are written over the
// cfg port (ready always high); the user must write them only while the
// block is idle, and the block itself does not enforce this.
module descriptor_index_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dia_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dia_pkg::rsp_t       rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  dia_pkg::reg_idx_t   cfg_index,
  input  logic [47:0]         cfg_data
);
  import dia_pkg::*;

  cfg_t cfg;
  req_t stage_item;
  logic stage_valid;
  logic advance;
  rsp_t core_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity     <= NULL_INDEX;
      cfg.slot_stride  <= STRIDE_W'(32);
      cfg.base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAPACITY: cfg.capacity     <= cfg_data[INDEX_W-1:0];
        REG_STRIDE:   cfg.slot_stride  <= cfg_data[STRIDE_W-1:0];
        REG_BASE:     cfg.base_address <= cfg_data[ADDR_W-1:0];
        default:      ;
      endcase
    end
  end

  assign advance   = stage_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      stage_item <= req;
    end
  end

  dia_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (stage_item),
    .cfg   (cfg),
    .result(core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= core_result;
    end
  end

  // stall towards the requester only comes from a held item in the stage
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (stage_valid && rsp_valid && rsp_stall))
    else $error("request stalled without a blocked item");

  a_null_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_index == NULL_INDEX) |-> (rsp.slot_address == '0))
    else $error("null index with non-zero address");

  a_full_null: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (rsp.result_index == NULL_INDEX))
    else $error("pool full result names a slot");

endmodule
